/* rtl/mec_pkg.sv */
// Shared types, constants and the colour palette of the escape-time colouring block.
// Used by every module under rtl; depends on nothing.
package mec_pkg;

  localparam int FRAC_BITS = 28;
  localparam int MAX_ITER  = 128;
  localparam int STEP_W    = 7;
  localparam int IN_W      = 32;
  localparam int THR_W     = 31;
  localparam int HALF_W    = 20;
  localparam int Z_W       = 2 * HALF_W;
  localparam int P_W       = 48;
  localparam int MUL_PP    = 4;

  localparam logic [63:0] THR_FULL = 64'd5 << FRAC_BITS;
  localparam logic [THR_W-1:0] THR_RESET =
    (THR_FULL > 64'h7FFF_FFFF) ? {THR_W{1'b1}} : THR_FULL[THR_W-1:0];

  typedef struct packed {
    logic signed [IN_W-1:0] c_real;
    logic signed [IN_W-1:0] c_imag;
  } in_req_t;

  typedef struct packed {
    logic [STEP_W-1:0] escape_step;
    logic              escaped;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } out_rsp_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [1:0] {
    OP_RR,
    OP_II,
    OP_RI
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_go;
    mul_op_t op;
    logic    update;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic esc_hit;
  } sts_t;

  function automatic rgb_t palette(input logic [STEP_W-1:0] step);
    rgb_t       c;
    logic [4:0] j;
    logic [7:0] j8;
    logic [7:0] j4;
    j  = step[4:0];
    j8 = {j, 3'b000};
    j4 = {1'b0, j, 2'b00};
    case (step[STEP_W-1 -: 2])
      2'd0: begin
        c.red   = j8;
        c.green = 8'd128 - j4;
        c.blue  = 8'd255 - j8;
      end
      2'd1: begin
        c.red   = 8'd255;
        c.green = j8;
        c.blue  = 8'd0;
      end
      2'd2: begin
        c.red   = 8'd128 - j4;
        c.green = 8'd255;
        c.blue  = j8;
      end
      default: begin
        c.red   = 8'd0;
        c.green = 8'd255 - j8;
        c.blue  = j8;
      end
    endcase
    return c;
  endfunction

endpackage

/* rtl/mec_mul.sv */
// Multi-cycle signed fixed-point multiplier: four 20x20 partial products, then floor shift.
// Depends on mec_pkg.
module mec_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic signed [mec_pkg::Z_W-1:0] a,
  input  logic signed [mec_pkg::Z_W-1:0] b,
  input  logic                          half,
  output logic                          done,
  output logic signed [mec_pkg::P_W-1:0] res
);

  logic [mec_pkg::Z_W-1:0]        ma_r;
  logic [mec_pkg::Z_W-1:0]        mb_r;
  logic                           neg_r;
  logic                           half_r;
  logic                           busy_r;
  logic [2:0]                     cnt_r;
  logic [2*mec_pkg::HALF_W-1:0]   prod_r;
  logic [1:0]                     pidx_r;
  logic                           pvld_r;
  logic [2*mec_pkg::Z_W-1:0]      acc_r;
  logic signed [mec_pkg::P_W-1:0] res_r;
  logic                           done_r;

  logic [mec_pkg::Z_W-1:0]        abs_a;
  logic [mec_pkg::Z_W-1:0]        abs_b;
  logic [mec_pkg::HALF_W-1:0]     part_a;
  logic [mec_pkg::HALF_W-1:0]     part_b;
  logic [1:0]                     pos;
  logic [2*mec_pkg::Z_W-1:0]      pp_ext;
  logic [2*mec_pkg::Z_W-1:0]      pp_add;
  logic signed [2*mec_pkg::Z_W:0] sfull;
  logic signed [2*mec_pkg::Z_W:0] shr;
  logic signed [mec_pkg::P_W-1:0] res_nxt;

  assign abs_a  = a[mec_pkg::Z_W-1] ? (~a + mec_pkg::Z_W'(1)) : a;
  assign abs_b  = b[mec_pkg::Z_W-1] ? (~b + mec_pkg::Z_W'(1)) : b;
  assign part_a = cnt_r[1] ? ma_r[mec_pkg::Z_W-1:mec_pkg::HALF_W] : ma_r[mec_pkg::HALF_W-1:0];
  assign part_b = cnt_r[0] ? mb_r[mec_pkg::Z_W-1:mec_pkg::HALF_W] : mb_r[mec_pkg::HALF_W-1:0];
  assign pos    = {1'b0, pidx_r[1]} + {1'b0, pidx_r[0]};
  assign pp_ext = {{(2*mec_pkg::Z_W-2*mec_pkg::HALF_W){1'b0}}, prod_r};

  always_comb begin
    case (pos)
      2'd0:    pp_add = pp_ext;
      2'd1:    pp_add = pp_ext << mec_pkg::HALF_W;
      default: pp_add = pp_ext << (2*mec_pkg::HALF_W);
    endcase
  end

  always_comb begin
    sfull   = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
    shr     = half_r ? (sfull >>> (mec_pkg::FRAC_BITS-1)) : (sfull >>> mec_pkg::FRAC_BITS);
    res_nxt = shr[mec_pkg::P_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      pvld_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pvld_r <= busy_r && (cnt_r < 3'(mec_pkg::MUL_PP));
      done_r <= !go && busy_r && (cnt_r == 3'(mec_pkg::MUL_PP + 1));
      if (go) begin
        ma_r   <= abs_a;
        mb_r   <= abs_b;
        neg_r  <= a[mec_pkg::Z_W-1] ^ b[mec_pkg::Z_W-1];
        half_r <= half;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r < 3'(mec_pkg::MUL_PP)) begin
          prod_r <= part_a * part_b;
          pidx_r <= cnt_r[1:0];
        end
        if (pvld_r) begin
          acc_r <= acc_r + pp_add;
        end
        if (cnt_r == 3'(mec_pkg::MUL_PP + 1)) begin
          res_r  <= res_nxt;
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

  assert property (@(posedge clk) disable iff (!rst_n) go |-> !busy_r)
    else $error("multiplier started while busy");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("multiplier done while still busy");
  assert property (@(posedge clk) disable iff (!rst_n) pvld_r |-> busy_r)
    else $error("partial product pending outside a multiply");

endmodule

/* rtl/mec_datapath.sv */
// Datapath: point and orbit registers, threshold register, shared multiplier, escape compare.
// Depends on mec_pkg and mec_mul.
module mec_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mec_pkg::in_req_t           in_req,
  input  logic                       cfg_we,
  input  logic [mec_pkg::THR_W-1:0]  cfg_wdata,
  input  mec_pkg::cmd_t              cmd,
  output mec_pkg::sts_t              sts
);

  logic signed [mec_pkg::IN_W-1:0] cr_r;
  logic signed [mec_pkg::IN_W-1:0] ci_r;
  logic signed [mec_pkg::Z_W-1:0]  re_r;
  logic signed [mec_pkg::Z_W-1:0]  im_r;
  logic signed [mec_pkg::P_W-1:0]  rr_r;
  logic signed [mec_pkg::P_W-1:0]  ii_r;
  logic signed [mec_pkg::P_W-1:0]  ri_r;
  logic [mec_pkg::THR_W-1:0]       thr_r;
  mec_pkg::mul_op_t                dst_r;

  logic signed [mec_pkg::Z_W-1:0]  mul_a;
  logic signed [mec_pkg::Z_W-1:0]  mul_b;
  logic                            mul_half;
  logic                            mul_done;
  logic signed [mec_pkg::P_W-1:0]  mul_res;
  logic signed [mec_pkg::P_W-1:0]  re_nxt;
  logic signed [mec_pkg::P_W-1:0]  im_nxt;
  logic [mec_pkg::P_W:0]           mag;

  always_comb begin
    unique case (cmd.op)
      mec_pkg::OP_RR: begin
        mul_a    = re_r;
        mul_b    = re_r;
        mul_half = 1'b0;
      end
      mec_pkg::OP_II: begin
        mul_a    = im_r;
        mul_b    = im_r;
        mul_half = 1'b0;
      end
      mec_pkg::OP_RI: begin
        mul_a    = re_r;
        mul_b    = im_r;
        mul_half = 1'b1;
      end
      default: begin
        mul_a    = re_r;
        mul_b    = im_r;
        mul_half = 1'b0;
      end
    endcase
  end

  mec_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .half  (mul_half),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign re_nxt = rr_r - ii_r
                + {{(mec_pkg::P_W-mec_pkg::IN_W){cr_r[mec_pkg::IN_W-1]}}, cr_r};
  assign im_nxt = ri_r
                + {{(mec_pkg::P_W-mec_pkg::IN_W){ci_r[mec_pkg::IN_W-1]}}, ci_r};
  assign mag    = {1'b0, rr_r} + {1'b0, ii_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= mec_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r <= in_req.c_real;
      ci_r <= in_req.c_imag;
      re_r <= {{(mec_pkg::Z_W-mec_pkg::IN_W){in_req.c_real[mec_pkg::IN_W-1]}},
               in_req.c_real};
      im_r <= {{(mec_pkg::Z_W-mec_pkg::IN_W){in_req.c_imag[mec_pkg::IN_W-1]}},
               in_req.c_imag};
    end else if (cmd.update) begin
      re_r <= re_nxt[mec_pkg::Z_W-1:0];
      im_r <= im_nxt[mec_pkg::Z_W-1:0];
    end
    if (cmd.mul_go) begin
      dst_r <= cmd.op;
    end
    if (mul_done) begin
      unique case (dst_r)
        mec_pkg::OP_RR: rr_r <= mul_res;
        mec_pkg::OP_II: ii_r <= mul_res;
        mec_pkg::OP_RI: ri_r <= mul_res;
        default:        ri_r <= mul_res;
      endcase
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.esc_hit  = mag > {{(mec_pkg::P_W+1-mec_pkg::THR_W){1'b0}}, thr_r};

endmodule

/* rtl/mec_ctrl.sv */
// Controller: sequences the multiplies of each iteration, counts iterations, forms the result.
// Depends on mec_pkg.
module mec_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output mec_pkg::cmd_t     cmd,
  input  mec_pkg::sts_t     sts,
  output logic              out_valid,
  output mec_pkg::out_rsp_t out_rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RR,
    S_RR_W,
    S_II,
    S_II_W,
    S_RI,
    S_RI_W,
    S_UPD,
    S_CHECK
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [mec_pkg::STEP_W-1:0]  iter_r;
  logic [mec_pkg::STEP_W-1:0]  iter_nxt;
  logic                        first_r;
  logic                        first_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  mec_pkg::out_rsp_t           out_rsp_r;
  mec_pkg::out_rsp_t           out_rsp_nxt;
  mec_pkg::rgb_t               colour;
  logic                        last_iter;

  assign colour    = mec_pkg::palette(iter_r);
  assign last_iter = iter_r == mec_pkg::STEP_W'(mec_pkg::MAX_ITER - 1);

  always_comb begin
    cmd.load   = (state_r == S_IDLE) && start;
    cmd.mul_go = (state_r == S_RR) || (state_r == S_II) || (state_r == S_RI);
    cmd.update = state_r == S_UPD;
    unique case (state_r)
      S_II, S_II_W: cmd.op = mec_pkg::OP_II;
      S_RI, S_RI_W: cmd.op = mec_pkg::OP_RI;
      default:      cmd.op = mec_pkg::OP_RR;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    first_nxt     = first_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RR;
          iter_nxt  = '0;
          first_nxt = 1'b1;
        end
      end
      S_RR:   state_nxt = S_RR_W;
      S_RR_W: begin
        if (sts.mul_done) begin
          state_nxt = S_II;
        end
      end
      S_II:   state_nxt = S_II_W;
      S_II_W: begin
        if (sts.mul_done) begin
          state_nxt = first_r ? S_RI : S_CHECK;
          first_nxt = 1'b0;
        end
      end
      S_RI:   state_nxt = S_RI_W;
      S_RI_W: begin
        if (sts.mul_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD:  state_nxt = S_RR;
      S_CHECK: begin
        if (sts.esc_hit) begin
          state_nxt               = S_IDLE;
          out_valid_nxt           = 1'b1;
          out_rsp_nxt.escape_step = iter_r;
          out_rsp_nxt.escaped     = 1'b1;
          out_rsp_nxt.red         = colour.red;
          out_rsp_nxt.green       = colour.green;
          out_rsp_nxt.blue        = colour.blue;
        end else if (last_iter) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '0;
        end else begin
          state_nxt = S_RI;
          iter_nxt  = iter_r + mec_pkg::STEP_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |-> !busy)
    else $error("result strobed while a request is still in progress");
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.escaped) |->
      (out_rsp_r.escape_step == '0 && out_rsp_r.red == '0 &&
       out_rsp_r.green == '0 && out_rsp_r.blue == '0))
    else $error("bounded point did not give black at step zero");
  assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_done |-> (state_r == S_RR_W || state_r == S_II_W || state_r == S_RI_W))
    else $error("multiplier finished outside a wait state");

endmodule

/* rtl/mandelbrot_escape_color_top.sv */
// Escape-time colouring of one point: the controller and datapath joined by commands and status.
// Time from accepted request to out_valid grows with the escape step n; a bounded point
// runs all MAX_ITER iterations. Each iteration makes three passes of the one multiplier,
// plus an update state and a compare state.
// A new request may be accepted in the cycle its predecessor's result is strobed.
// Synchronous active-low reset idles the block and sets the threshold to 5.0.
module mandelbrot_escape_color_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  mec_pkg::in_req_t          in_req,
  input  logic                      cfg_we,
  input  logic [mec_pkg::THR_W-1:0] cfg_wdata,
  output logic                      out_valid,
  output mec_pkg::out_rsp_t         out_rsp
);

  mec_pkg::cmd_t cmd;
  mec_pkg::sts_t sts;

  mec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  mec_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for mandelbrot_escape_color_top: random and directed points
// with an escape-time predictor in a scoreboard class. Depends on rtl/mec_pkg.sv and the RTL.
module testbench;

  localparam int CYCLE_LIMIT = 12_000_000;
  localparam longint PRODUCT_CAP = 64'sd1 <<< 60;

  class escape_scoreboard;
    longint            threshold;
    mec_pkg::out_rsp_t colours[$];
    int                mismatches;

    function new();
      threshold  = (64'd5 << mec_pkg::FRAC_BITS) > 64'h7FFF_FFFF ? 64'h7FFF_FFFF
                                                                 : (64'd5 << mec_pkg::FRAC_BITS);
      mismatches = 0;
    endfunction

    function void load_threshold(logic [mec_pkg::THR_W-1:0] value);
      threshold = {33'd0, value};
    endfunction

    // Exact product, floored shift by the fraction width, magnitude capped at 2^60.
    function longint scaled_product(longint a, longint b);
      logic signed [127:0] wide;
      wide = a;
      wide = wide * b;
      wide = wide >>> mec_pkg::FRAC_BITS;
      if (wide > PRODUCT_CAP) return PRODUCT_CAP;
      if (wide < -PRODUCT_CAP) return -PRODUCT_CAP;
      return longint'(wide);
    endfunction

    function mec_pkg::out_rsp_t predict_escape(mec_pkg::in_req_t p);
      longint            cr, ci, re, im, nre, nim, mag;
      int                j;
      mec_pkg::out_rsp_t r;
      cr = longint'($signed(p.c_real));
      ci = longint'($signed(p.c_imag));
      re = cr;
      im = ci;
      r  = '0;
      for (int i = 0; i < mec_pkg::MAX_ITER && !r.escaped; i++) begin
        nre = scaled_product(re, re) - scaled_product(im, im) + cr;
        nim = scaled_product(re + re, im) + ci;
        re  = nre;
        im  = nim;
        mag = scaled_product(re, re) + scaled_product(im, im);
        if (mag > threshold) begin
          j = i % 32;
          r.escape_step = mec_pkg::STEP_W'(i);
          r.escaped     = 1'b1;
          case (i / 32)
            0: begin
              r.red   = 8'(8 * j);
              r.green = 8'(128 - 4 * j);
              r.blue  = 8'(255 - 8 * j);
            end
            1: begin
              r.red   = 8'd255;
              r.green = 8'(8 * j);
              r.blue  = 8'd0;
            end
            2: begin
              r.red   = 8'(128 - 4 * j);
              r.green = 8'd255;
              r.blue  = 8'(8 * j);
            end
            default: begin
              r.red   = 8'd0;
              r.green = 8'(255 - 8 * j);
              r.blue  = 8'(8 * j);
            end
          endcase
        end
      end
      return r;
    endfunction

    function string show(mec_pkg::out_rsp_t r);
      return $sformatf("step %0d escaped %0b rgb %02h %02h %02h",
                       r.escape_step, r.escaped, r.red, r.green, r.blue);
    endfunction

    function void record(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void note_point(mec_pkg::in_req_t p);
      colours = {colours, predict_escape(p)};
    endfunction

    function void check_colour(mec_pkg::out_rsp_t got);
      mec_pkg::out_rsp_t want;
      if (colours.size() == 0) begin
        record({"unexpected result: ", show(got)});
        return;
      end
      want = colours.pop_front();
      if (got.escape_step !== want.escape_step || got.escaped !== want.escaped ||
          got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
        record({"expected ", show(want), ", got ", show(got)});
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  mec_pkg::in_req_t          in_req;
  logic                      cfg_we;
  logic [mec_pkg::THR_W-1:0] cfg_wdata;
  logic                      out_valid;
  mec_pkg::out_rsp_t         out_rsp;
  int                        cycles = 0;
  escape_scoreboard          books;

  mandelbrot_escape_color_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) books.check_colour(out_rsp);
      if (start && !busy) books.note_point(in_req);
      if (cfg_we) books.load_threshold(cfg_wdata);
    end
  end

  function automatic longint fx(real x);
    return longint'($rtoi(x * (1 << mec_pkg::FRAC_BITS)));
  endfunction

  function automatic mec_pkg::in_req_t mk(longint re, longint im);
    mec_pkg::in_req_t p;
    p.c_real = re[31:0];
    p.c_imag = im[31:0];
    return p;
  endfunction

  // Presents one request after an optional gap or wait for idle, and returns once it has been taken.
  task automatic send_point(mec_pkg::in_req_t p, int gap, bit settle);
    @(negedge clk);
    if (gap > 0 || (settle && busy)) begin
      start <= 1'b0;
      while (settle && busy) @(negedge clk);
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (books.colours.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic set_threshold(logic [mec_pkg::THR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_list(mec_pkg::in_req_t points[$]);
    foreach (points[k])
      send_point(points[k], int'($urandom_range(0, 13)), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_random(int count);
    mec_pkg::in_req_t p;
    int               sel;
    bit               calm;
    calm = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      sel = int'($urandom_range(0, 99));
      if (sel < 40)
        p = mk(longint'($urandom), longint'($urandom));
      else if (sel < 85)
        p = mk(fx(-2.0) + longint'($urandom_range(0, 32'(fx(2.5)))),
               fx(-1.25) + longint'($urandom_range(0, 32'(fx(2.5)))));
      else if (sel < 95)
        p = mk(fx(0.25) + longint'($urandom_range(0, 32'(fx(0.01)))),
               longint'($urandom_range(0, 32'(fx(0.002)))) - fx(0.001));
      else
        p = mk(longint'($urandom_range(0, 64)) - 32, longint'($urandom_range(0, 64)) - 32);
      if (calm) send_point(p, 0, 1'b0);
      else send_point(p, int'($urandom_range(0, 13)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    mec_pkg::in_req_t points[$];
    books     = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    points = '{mk(0, 0), mk(fx(-1.0), 0), mk(fx(-2.0), 0), mk(0, fx(1.0)), mk(0, fx(-1.0)),
               mk(fx(0.25), 0), mk(fx(0.26), 0), mk(fx(0.255), 0), mk(fx(0.2515), 0),
               mk(fx(0.2508), 0), mk(fx(2.0), fx(2.0)), mk(fx(0.5), fx(0.5)),
               mk(fx(-0.75), fx(0.1)), mk(64'sh7FFF_FFFF, 64'sh7FFF_FFFF),
               mk(-64'sd2147483648, -64'sd2147483648), mk(-64'sd2147483648, 64'sh7FFF_FFFF),
               mk(64'sh7FFF_FFFF, -64'sd2147483648), mk(-64'sd2147483648, 0),
               mk(0, -64'sd2147483648)};
    send_list(points);
    run_random(200);
    drain();

    set_threshold('0);
    points = '{mk(0, 0), mk(1, 0), mk(-1, 0), mk(0, -1)};
    send_list(points);
    run_random(200);
    drain();

    set_threshold('1);
    run_random(200);
    drain();

    set_threshold(mec_pkg::THR_W'(64'd4 << mec_pkg::FRAC_BITS));
    points = '{mk(fx(-2.0), 0), mk(fx(2.0), 0)};
    send_list(points);
    run_random(200);
    drain();

    set_threshold(mec_pkg::THR_W'($urandom_range(0, 32'h7FFF_FFFF)));
    run_random(200);
    drain();

    foreach (books.colours[k]) books.record({"missing result: ", books.show(books.colours[k])});
    if (books.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
